// ----- hdl/playfair_digraph_cipher_top_macros.svh -----
// assertion macros for the playfair digraph cipher block
// expects clk and arst_n in the scope of use
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PDC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdc check failed");

// next-cycle implication, checked outside reset
`define PDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdc check failed");

`endif

// ----- hdl/pdc_pkg.sv -----
// shared types, codes and small square helpers for the playfair block
// no dependencies
package pdc_pkg;

	localparam logic [4:0] LETTER_I     = 5'd8;
	localparam logic [4:0] LETTER_J     = 5'd9;
	localparam logic [4:0] LETTER_X     = 5'd23;
	localparam logic [4:0] LETTER_LAST  = 5'd25;
	localparam logic [4:0] SQUARE_CELLS = 5'd25;
	localparam logic [6:0] ASCII_LOWER_A = 7'd97;

	typedef enum logic [2:0] {
		FN_KEY_BEGIN = 3'd0,
		FN_KEY_CHAR  = 3'd1,
		FN_KEY_END   = 3'd2,
		FN_ENCRYPT   = 3'd3,
		FN_DECRYPT   = 3'd4,
		FN_MSG_END   = 3'd5
	} func_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] idx;
	} letter_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} coord_t;

	// letter index with j folded onto i
	function automatic letter_t letter_of(input logic [7:0] ch);
		letter_t r;
		logic [7:0] d;
		r.ok = 1'b0;
		d = 8'd0;
		if (ch >= 8'd65 && ch <= 8'd90) begin
			r.ok = 1'b1;
			d = ch - 8'd65;
		end else if (ch >= 8'd97 && ch <= 8'd122) begin
			r.ok = 1'b1;
			d = ch - 8'd97;
		end
		r.idx = d[4:0];
		if (r.idx == LETTER_J) begin
			r.idx = LETTER_I;
		end
		return r;
	endfunction

	// cell number to row and column
	function automatic coord_t coord_of(input logic [4:0] p);
		coord_t c;
		logic [4:0] q;
		logic [4:0] base;
		q = (p >= SQUARE_CELLS) ? p - SQUARE_CELLS : p;
		if (q >= 5'd20) begin
			c.row = 3'd4;
			base = 5'd20;
		end else if (q >= 5'd15) begin
			c.row = 3'd3;
			base = 5'd15;
		end else if (q >= 5'd10) begin
			c.row = 3'd2;
			base = 5'd10;
		end else if (q >= 5'd5) begin
			c.row = 3'd1;
			base = 5'd5;
		end else begin
			c.row = 3'd0;
			base = 5'd0;
		end
		c.col = 3'(q - base);
		return c;
	endfunction

	// one step round the square, backwards when decrypting
	function automatic logic [2:0] step5(input logic [2:0] x, input logic back);
		logic [2:0] r;
		if (back) begin
			r = (x == 3'd0) ? 3'd4 : x - 3'd1;
		end else begin
			r = (x == 3'd4) ? 3'd0 : x + 3'd1;
		end
		return r;
	endfunction

	function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
		return {row, 2'b00} + {2'b00, row} + {2'b00, col};
	endfunction

endpackage

// ----- hdl/pdc_stream_if.sv -----
// valid/ready channels for the playfair block: command words in, letter words out
// depends on nothing
interface pdc_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] char_in;

	modport source (output valid, output func, output char_in, input ready);
	modport sink (input valid, input func, input char_in, output ready);
endinterface

interface pdc_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_out;
	logic       last_of_run;

	modport source (output valid, output char_out, output last_of_run, input ready);
	modport sink (input valid, input char_out, input last_of_run, output ready);
endinterface

// ----- hdl/playfair_digraph_cipher_top.sv -----
// Playfair engine: key square build, digraph encrypt and decrypt.
// Key begin, key char, message end without output and single text letters are each handled in the idle state.
// Key end: the fill walk visits each alphabet letter once.
// A text word that completes a pair steps through PA, PB, CALC, LD1, E1, LD2 and E2 to the last letter word,
// holding in E1 or E2 while the output stalls; the position and square memories are read once per cycle.
// arst_n clears control state; the square memories hold garbage until the key is built.
`include "playfair_digraph_cipher_top_macros.svh"

module playfair_digraph_cipher_top (
	input logic clk,
	input logic arst_n,
	pdc_cmd_if.sink cmd,
	pdc_res_if.source res
);
	import pdc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_PA,
		S_PB,
		S_CALC,
		S_LD1,
		S_E1,
		S_LD2,
		S_E2
	} state_t;

	state_t     state_q;
	logic [25:0] seen_q;
	logic [4:0] fill_q;
	logic [4:0] held_q;
	logic       held_valid_q;
	logic       held_dec_q;
	logic [4:0] l_q;
	logic [4:0] a_q;
	logic [4:0] b_q;
	logic       dec_q;
	logic [4:0] pa_q;
	logic [4:0] cell1_q;
	logic [4:0] cell2_q;
	logic       ovalid_q;
	logic [6:0] ochar_q;
	logic       olast_q;

	logic [4:0] pos_mem [0:25];
	logic [4:0] sq_mem [0:24];
	logic [4:0] rd_pos;
	logic [4:0] rd_sq;
	logic [4:0] pos_raddr;
	logic [4:0] sq_raddr;

	logic       cmd_fire;
	func_t      cmd_func;
	letter_t    in_let;
	logic       in_dec;
	logic       place_req;
	logic       place_en;
	logic [4:0] place_idx;
	logic       slot_free;
	logic       emit_now;
	coord_t     ca;
	coord_t     cb;
	logic [4:0] cell1;
	logic [4:0] cell2;
	logic [6:0] sq_char;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire = cmd.valid && cmd.ready;
	assign cmd_func = func_t'(cmd.func);
	assign in_let = letter_of(cmd.char_in);
	assign in_dec = (cmd_func == FN_DECRYPT);
	assign slot_free = !ovalid_q || res.ready;
	assign emit_now = (state_q == S_E1 || state_q == S_E2) && slot_free;

	assign res.valid = ovalid_q;
	assign res.char_out = ochar_q;
	assign res.last_of_run = olast_q;

	// one placement per cycle, from a key word or from the fill walk
	always_comb begin
		if (state_q == S_FILL) begin
			place_idx = l_q;
			place_req = (l_q != LETTER_J);
		end else begin
			place_idx = in_let.idx;
			place_req = cmd_fire && (cmd_func == FN_KEY_CHAR) && in_let.ok;
		end
		place_en = place_req && (fill_q < SQUARE_CELLS) && !seen_q[place_idx];
	end

	assign pos_raddr = (state_q == S_PB) ? b_q : a_q;
	assign sq_raddr = (state_q == S_LD2 || state_q == S_E2) ? cell2_q : cell1_q;
	assign sq_char = ASCII_LOWER_A + {2'b00, rd_sq};

	// shared square unit: both coordinates in, both substitute cells out
	always_comb begin
		ca = coord_of(pa_q);
		cb = coord_of(rd_pos);
		if (ca.row == cb.row) begin
			cell1 = cell_of(ca.row, step5(ca.col, dec_q));
			cell2 = cell_of(cb.row, step5(cb.col, dec_q));
		end else if (ca.col == cb.col) begin
			cell1 = cell_of(step5(ca.row, dec_q), ca.col);
			cell2 = cell_of(step5(cb.row, dec_q), cb.col);
		end else begin
			cell1 = cell_of(ca.row, cb.col);
			cell2 = cell_of(cb.row, ca.col);
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			pos_mem[place_idx] <= fill_q;
		end
		rd_pos <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			sq_mem[fill_q] <= place_idx;
		end
		rd_sq <= sq_mem[sq_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q <= '0;
			fill_q <= '0;
			held_q <= '0;
			held_valid_q <= 1'b0;
			held_dec_q <= 1'b0;
			l_q <= '0;
			a_q <= '0;
			b_q <= '0;
			dec_q <= 1'b0;
			pa_q <= '0;
			cell1_q <= '0;
			cell2_q <= '0;
			ovalid_q <= 1'b0;
			ochar_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (ovalid_q && res.ready && !emit_now) begin
				ovalid_q <= 1'b0;
			end
			if (place_en) begin
				seen_q[place_idx] <= 1'b1;
				fill_q <= fill_q + 5'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						case (cmd_func) inside
							FN_KEY_BEGIN: begin
								seen_q <= '0;
								fill_q <= '0;
								held_valid_q <= 1'b0;
							end
							FN_KEY_END: begin
								l_q <= '0;
								state_q <= S_FILL;
							end
							FN_ENCRYPT, FN_DECRYPT: begin
								if (in_let.ok) begin
									if (!held_valid_q || held_dec_q != in_dec) begin
										held_q <= in_let.idx;
										held_valid_q <= 1'b1;
										held_dec_q <= in_dec;
									end else if (!in_dec && held_q == in_let.idx) begin
										// doubled letter: pad with x, the new one stays held
										a_q <= in_let.idx;
										b_q <= LETTER_X;
										dec_q <= 1'b0;
										state_q <= S_PA;
									end else begin
										held_valid_q <= 1'b0;
										a_q <= held_q;
										b_q <= in_let.idx;
										dec_q <= in_dec;
										state_q <= S_PA;
									end
								end
							end
							FN_MSG_END: begin
								held_valid_q <= 1'b0;
								if (held_valid_q && !held_dec_q) begin
									a_q <= held_q;
									b_q <= LETTER_X;
									dec_q <= 1'b0;
									state_q <= S_PA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FILL: begin
					if (l_q == LETTER_LAST) begin
						held_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						l_q <= l_q + 5'd1;
					end
				end
				S_PA: state_q <= S_PB;
				S_PB: begin
					pa_q <= rd_pos;
					state_q <= S_CALC;
				end
				S_CALC: begin
					cell1_q <= cell1;
					cell2_q <= cell2;
					state_q <= S_LD1;
				end
				S_LD1: state_q <= S_E1;
				S_E1: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						ochar_q <= sq_char;
						olast_q <= 1'b0;
						state_q <= S_LD2;
					end
				end
				S_LD2: state_q <= S_E2;
				S_E2: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						ochar_q <= sq_char;
						olast_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PDC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= SQUARE_CELLS)
	`PDC_ASSERT_NEXT(a_second_last, state_q == S_E2 && slot_free, ovalid_q && olast_q)
	`PDC_ASSERT_NEXT(a_first_not_last, state_q == S_E1 && slot_free, ovalid_q && !olast_q)
	`PDC_ASSERT_NEXT(a_fill_walk, state_q == S_FILL && l_q != LETTER_LAST, l_q == 5'($past(l_q) + 5'd1))
	`PDC_ASSERT_NEXT(a_key_begin, cmd_fire && cmd_func == FN_KEY_BEGIN, fill_q == 5'd0 && seen_q == 26'd0 && !held_valid_q)

endmodule
